FILE: design/nfp_pkg.sv
// Shared types, constants, micro-program and arithmetic helpers of the Newton fractal pixel core.
`default_nettype none
package nfp_pkg;

  // Fixed-point format: signed Q15.32 in 48 bits.
  localparam int unsigned FX_W    = 48;
  localparam int unsigned ACC_W   = 96;
  localparam int unsigned DIV_W   = 80;
  localparam int unsigned COORD_W = 19;
  localparam int unsigned PROD_W  = 52;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned PC_W    = 6;
  localparam int unsigned RF_DEPTH = 13;

  localparam logic [FX_W-1:0] FX_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [FX_W-1:0] FX_MIN  = 48'h8000_0000_0000;
  localparam logic [FX_W-1:0] FX_ONE  = 48'h0001_0000_0000;
  localparam logic [FX_W-1:0] FX_HALF = 48'h0000_8000_0000;
  localparam logic [FX_W-1:0] FX_S3H  = 48'd3719550787;
  localparam logic signed [FX_W+1:0] FX_TOL = 50'sd429;

  // Configuration register map.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_REC = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd3;
  localparam logic [31:0] ZOOM_RESET     = 32'd83886;
  localparam logic [7:0]  MAX_ITER_RESET = 8'd50;

  localparam int unsigned IMAGE_WIDTH_DEF  = 800;
  localparam int unsigned IMAGE_HEIGHT_DEF = 600;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_MUL3, OP_DIV, OP_INITR, OP_INITI,
    OP_CHKOVF, OP_CHKDD, OP_TEST, OP_DIVA
  } op_e;

  // Working registers; RF_ONE reads the constant 1.0.
  typedef enum logic [3:0] {
    RF_ZR, RF_ZI, RF_Z2R, RF_Z2I, RF_T0, RF_T1, RF_NR, RF_NI,
    RF_DR, RF_DI, RF_DD, RF_QR, RF_QI, RF_ONE
  } rf_e;

  typedef struct packed {
    op_e op;
    rf_e dst;
    rf_e srca;
    rf_e srcb;
  } uop_t;

  typedef struct packed {
    logic       start;
    uop_t       uop;
    logic [7:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic       done;
    logic       abort;
    logic       hit;
    logic [1:0] root;
    logic [7:0] alpha;
  } dp_sts_t;

  typedef struct packed {
    logic [FX_W-1:0] val;
    logic            ovf;
  } fx_res_t;

  // Program addresses the controller branches on.
  localparam logic [PC_W-1:0] PC_INIT_CHK = 6'd2;
  localparam logic [PC_W-1:0] PC_LOOP     = 6'd3;
  localparam logic [PC_W-1:0] PC_TEST     = 6'd31;
  localparam logic [PC_W-1:0] PC_ALPHA    = 6'd32;

  function automatic uop_t mk_uop(input op_e o, input rf_e d, input rf_e a, input rf_e b);
    uop_t u;
    u.op = o; u.dst = d; u.srca = a; u.srcb = b;
    return u;
  endfunction

  // Start point, then one Newton step z -= (z^3-1)/(3z^2), then the root test and the alpha division.
  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk_uop(OP_INITR,  RF_ZR,  RF_ZR,  RF_ZR);
      6'd1:  u = mk_uop(OP_INITI,  RF_ZI,  RF_ZR,  RF_ZR);
      6'd2:  u = mk_uop(OP_CHKOVF, RF_ZR,  RF_ZR,  RF_ZR);
      6'd3:  u = mk_uop(OP_MUL,    RF_T0,  RF_ZR,  RF_ZR);
      6'd4:  u = mk_uop(OP_MUL,    RF_T1,  RF_ZI,  RF_ZI);
      6'd5:  u = mk_uop(OP_SUB,    RF_Z2R, RF_T0,  RF_T1);
      6'd6:  u = mk_uop(OP_MUL,    RF_T0,  RF_ZR,  RF_ZI);
      6'd7:  u = mk_uop(OP_ADD,    RF_Z2I, RF_T0,  RF_T0);
      6'd8:  u = mk_uop(OP_MUL,    RF_T0,  RF_Z2R, RF_ZR);
      6'd9:  u = mk_uop(OP_MUL,    RF_T1,  RF_Z2I, RF_ZI);
      6'd10: u = mk_uop(OP_SUB,    RF_NR,  RF_T0,  RF_T1);
      6'd11: u = mk_uop(OP_MUL,    RF_T0,  RF_Z2R, RF_ZI);
      6'd12: u = mk_uop(OP_MUL,    RF_T1,  RF_Z2I, RF_ZR);
      6'd13: u = mk_uop(OP_ADD,    RF_NI,  RF_T0,  RF_T1);
      6'd14: u = mk_uop(OP_SUB,    RF_NR,  RF_NR,  RF_ONE);
      6'd15: u = mk_uop(OP_MUL3,   RF_DR,  RF_Z2R, RF_Z2R);
      6'd16: u = mk_uop(OP_MUL3,   RF_DI,  RF_Z2I, RF_Z2I);
      6'd17: u = mk_uop(OP_MUL,    RF_T0,  RF_DR,  RF_DR);
      6'd18: u = mk_uop(OP_MUL,    RF_T1,  RF_DI,  RF_DI);
      6'd19: u = mk_uop(OP_ADD,    RF_DD,  RF_T0,  RF_T1);
      6'd20: u = mk_uop(OP_CHKDD,  RF_DD,  RF_DD,  RF_DD);
      6'd21: u = mk_uop(OP_MUL,    RF_T0,  RF_NR,  RF_DR);
      6'd22: u = mk_uop(OP_MUL,    RF_T1,  RF_NI,  RF_DI);
      6'd23: u = mk_uop(OP_ADD,    RF_T0,  RF_T0,  RF_T1);
      6'd24: u = mk_uop(OP_DIV,    RF_QR,  RF_T0,  RF_DD);
      6'd25: u = mk_uop(OP_MUL,    RF_T0,  RF_NI,  RF_DR);
      6'd26: u = mk_uop(OP_MUL,    RF_T1,  RF_NR,  RF_DI);
      6'd27: u = mk_uop(OP_SUB,    RF_T0,  RF_T0,  RF_T1);
      6'd28: u = mk_uop(OP_DIV,    RF_QI,  RF_T0,  RF_DD);
      6'd29: u = mk_uop(OP_SUB,    RF_ZR,  RF_ZR,  RF_QR);
      6'd30: u = mk_uop(OP_SUB,    RF_ZI,  RF_ZI,  RF_QI);
      6'd31: u = mk_uop(OP_TEST,   RF_ZR,  RF_ZR,  RF_ZI);
      6'd32: u = mk_uop(OP_DIVA,   RF_ZR,  RF_ZR,  RF_ZR);
      default: u = mk_uop(OP_CHKOVF, RF_ZR, RF_ZR, RF_ZR);
    endcase
    return u;
  endfunction

  function automatic logic [FX_W-1:0] fx_mag(input logic [FX_W-1:0] a);
    return a[FX_W-1] ? (48'd0 - a) : a;
  endfunction

  // Applies the sign to a magnitude and flags values outside the format.
  function automatic fx_res_t fx_finish(input logic [63:0] r, input logic neg);
    fx_res_t res;
    logic [63:0] lim;
    lim = 64'h0000_8000_0000_0000;
    if (r > lim || (r == lim && !neg)) begin
      res.ovf = 1'b1;
      res.val = neg ? FX_MIN : FX_MAX;
    end else begin
      res.ovf = 1'b0;
      res.val = neg ? (48'd0 - r[FX_W-1:0]) : r[FX_W-1:0];
    end
    return res;
  endfunction

  // Saturates a 50-bit signed sum to the 48-bit format.
  function automatic fx_res_t fx_sat(input logic [FX_W+1:0] s);
    fx_res_t res;
    res.ovf = !(s[FX_W+1:FX_W-1] == 3'b000 || s[FX_W+1:FX_W-1] == 3'b111);
    if (res.ovf) res.val = s[FX_W+1] ? FX_MIN : FX_MAX;
    else         res.val = s[FX_W-1:0];
    return res;
  endfunction

  function automatic logic [FX_W-1:0] root_re(input logic [1:0] k);
    return (k == 2'd0) ? FX_ONE : (48'd0 - FX_HALF);
  endfunction

  function automatic logic [FX_W-1:0] root_im(input logic [1:0] k);
    logic [FX_W-1:0] v;
    case (k)
      2'd0:    v = '0;
      2'd1:    v = FX_S3H;
      default: v = 48'd0 - FX_S3H;
    endcase
    return v;
  endfunction

  // Palette as {red, green, blue}.
  function automatic logic [23:0] palette(input logic [1:0] k);
    logic [23:0] c;
    case (k)
      2'd0:    c = {8'd154, 8'd93, 8'd93};
      2'd1:    c = {8'd109, 8'd167, 8'd109};
      default: c = {8'd99, 8'd129, 8'd159};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/nfp_datapath.sv
// Datapath: working registers, sequential multiplier, restoring divider, adders and root test.
`default_nettype none
module nfp_datapath #(
  parameter int unsigned IMAGE_WIDTH  = nfp_pkg::IMAGE_WIDTH_DEF,
  parameter int unsigned IMAGE_HEIGHT = nfp_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nfp_pkg::dp_cmd_t cmd_i,
  input  logic             pix_load_i,
  input  logic [9:0]       pixel_x_i,
  input  logic [9:0]       pixel_y_i,
  input  logic [15:0]      offset_x_i,
  input  logic [15:0]      offset_y_i,
  input  logic [31:0]      zoom_reciprocal_i,
  input  logic [7:0]       max_iterations_i,
  output nfp_pkg::dp_sts_t sts_o
);
  import nfp_pkg::*;

  logic [FX_W-1:0]   rf_q [RF_DEPTH];
  logic [FX_W-1:0]   a_q, b_q;
  logic [9:0]        px_q, py_q;
  op_e               op_q;
  rf_e               dst_q;
  logic              busy_q, ovf_q;
  logic [CNT_W-1:0]  cnt_q, last_cnt;
  logic [ACC_W-1:0]  acc_q, acc_nx, mul_t;
  logic [DIV_W-1:0]  num_q, quo_q;
  logic [FX_W-1:0]   rem_q, rem_nx;
  logic [FX_W:0]     rem_sh;
  logic              ge;
  logic signed [PROD_W-1:0] prod_q, prod_nx;
  logic [7:0]        alpha_q;
  logic              done, neg, wr_en, div_big, init_ok;
  logic [FX_W-1:0]   ua, ub;
  logic [15:0]       chunk;
  logic [63:0]       pp;
  logic [FX_W+1:0]   sa, sb, addsub, s3;
  logic [COORD_W-1:0] cx, cy;
  logic signed [COORD_W-1:0] coord;
  fx_res_t           mul_res, div_res, init_res, wr_res;
  logic              hit;
  logic [1:0]        root;
  logic signed [FX_W+1:0] er, ei;

  // Count value at which each operation is done.
  always_comb begin
    case (op_q)
      OP_MUL:           last_cnt = CNT_W'(3);
      OP_DIV, OP_DIVA:  last_cnt = CNT_W'(DIV_W + 1);
      OP_INITR, OP_INITI: last_cnt = CNT_W'(1);
      default:          last_cnt = '0;
    endcase
  end
  assign done = busy_q && (cnt_q == last_cnt);

  // Multiplier: 48 x 16 bits per cycle over the three 16-bit chunks of b, then rounding.
  assign ua  = fx_mag(a_q);
  assign ub  = fx_mag(b_q);
  assign neg = a_q[FX_W-1] ^ b_q[FX_W-1];
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    chunk = ub[47:32];
      2'd1:    chunk = ub[31:16];
      default: chunk = ub[15:0];
    endcase
  end
  assign pp      = 64'(ua) * 64'(chunk);
  assign acc_nx  = {acc_q[ACC_W-17:0], 16'h0000} + {32'h0, pp};
  assign mul_t   = acc_q + ACC_W'(64'h8000_0000);
  assign mul_res = fx_finish(mul_t[ACC_W-1:32], neg);

  // Restoring divider, one quotient bit per cycle.
  assign rem_sh  = {rem_q, num_q[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, b_q};
  assign rem_nx  = ge ? FX_W'(rem_sh - {1'b0, b_q}) : rem_sh[FX_W-1:0];
  assign div_big = quo_q[DIV_W-1:32] > 48'd32768;
  assign div_res = fx_finish({15'd0, quo_q[FX_W:0]}, a_q[FX_W-1]);

  // Adder and times-three.
  assign sa     = {{2{a_q[FX_W-1]}}, a_q};
  assign sb     = {{2{b_q[FX_W-1]}}, b_q};
  assign addsub = (op_q == OP_SUB) ? (sa - sb) : (sa + sb);
  assign s3     = sa + {sa[FX_W:0], 1'b0};

  // Start point: pixel offset from the image center plus the view offset, times the zoom.
  assign cx = {{(COORD_W-11){1'b0}}, px_q, 1'b0} - COORD_W'(IMAGE_WIDTH)
              + {{(COORD_W-17){offset_x_i[15]}}, offset_x_i, 1'b0};
  assign cy = COORD_W'(IMAGE_HEIGHT) + {{(COORD_W-17){offset_y_i[15]}}, offset_y_i, 1'b0}
              - {{(COORD_W-11){1'b0}}, py_q, 1'b0};
  assign coord   = (op_q == OP_INITI) ? signed'(cy) : signed'(cx);
  assign prod_nx = coord * $signed({1'b0, zoom_reciprocal_i});
  assign init_ok = (&prod_q[PROD_W-1:40]) || !(|prod_q[PROD_W-1:40]);
  always_comb begin
    init_res.ovf = !init_ok;
    if (init_ok) init_res.val = {prod_q[40:0], 7'd0};
    else         init_res.val = prod_q[PROD_W-1] ? FX_MIN : FX_MAX;
  end

  // Result selection for the register write.
  always_comb begin
    case (op_q)
      OP_ADD, OP_SUB:     wr_res = fx_sat(addsub);
      OP_MUL3:            wr_res = fx_sat(s3);
      OP_MUL:             wr_res = mul_res;
      OP_DIV: begin
        if (div_big) begin
          wr_res.val = a_q[FX_W-1] ? FX_MIN : FX_MAX;
          wr_res.ovf = 1'b1;
        end else begin
          wr_res = div_res;
        end
      end
      OP_INITR, OP_INITI: wr_res = init_res;
      default: begin
        wr_res.val = '0;
        wr_res.ovf = 1'b0;
      end
    endcase
  end
  assign wr_en = done && (op_q == OP_ADD || op_q == OP_SUB || op_q == OP_MUL ||
                          op_q == OP_MUL3 || op_q == OP_DIV || op_q == OP_INITR ||
                          op_q == OP_INITI);

  // Root test on z, captured as operands a and b.
  always_comb begin
    hit  = 1'b0;
    root = 2'd0;
    er   = '0;
    ei   = '0;
    for (int k = 2; k >= 0; k--) begin
      er = signed'(sa) - (FX_W+2)'(signed'(root_re(2'(k))));
      ei = signed'(sb) - (FX_W+2)'(signed'(root_im(2'(k))));
      if (er < FX_TOL && er > -FX_TOL && ei < FX_TOL && ei > -FX_TOL) begin
        hit  = 1'b1;
        root = 2'(k);
      end
    end
  end

  always_comb begin
    sts_o.done  = done;
    sts_o.abort = ovf_q || (op_q == OP_CHKDD && (a_q[FX_W-1] || a_q == '0));
    sts_o.hit   = hit;
    sts_o.root  = root;
    sts_o.alpha = alpha_q;
  end

  // Operation sequencing and the sticky overflow flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_CHKOVF;
      dst_q  <= RF_ZR;
      ovf_q  <= 1'b0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      op_q   <= cmd_i.uop.op;
      dst_q  <= cmd_i.uop.dst;
      if (cmd_i.uop.op == OP_INITR) ovf_q <= 1'b0;
    end else if (busy_q) begin
      if (done) begin
        busy_q <= 1'b0;
        if (wr_en) ovf_q <= ovf_q | wr_res.ovf;
      end else begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // Register file, operand capture and arithmetic state.
  always_ff @(posedge clk_i) begin
    if (pix_load_i) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
    if (wr_en) rf_q[dst_q] <= wr_res.val;
    if (cmd_i.start) begin
      acc_q <= '0;
      if (cmd_i.uop.op == OP_DIVA) begin
        a_q <= {32'd0, ({cmd_i.step, 8'd0} - {8'd0, cmd_i.step})};
        b_q <= {40'd0, max_iterations_i};
      end else begin
        a_q <= (cmd_i.uop.srca == RF_ONE) ? FX_ONE : rf_q[cmd_i.uop.srca];
        b_q <= (cmd_i.uop.srcb == RF_ONE) ? FX_ONE : rf_q[cmd_i.uop.srcb];
      end
    end else if (busy_q && !done) begin
      if (op_q == OP_MUL) acc_q <= acc_nx;
      if (op_q == OP_DIV || op_q == OP_DIVA) begin
        if (cnt_q == '0) begin
          num_q <= {ua, 32'd0};
          rem_q <= '0;
          quo_q <= '0;
        end else begin
          num_q <= {num_q[DIV_W-2:0], 1'b0};
          rem_q <= rem_nx;
          quo_q <= {quo_q[DIV_W-2:0], ge};
        end
      end
      if ((op_q == OP_INITR || op_q == OP_INITI) && cnt_q == '0) prod_q <= prod_nx;
    end
    if (done && op_q == OP_DIVA) alpha_q <= quo_q[39:32];
  end

endmodule
`default_nettype wire

FILE: design/nfp_ctrl.sv
// Controller: micro-program sequencer, step loop and result register.
`default_nettype none
module nfp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             pix_load_o,
  input  logic [7:0]       max_iterations_i,
  output nfp_pkg::dp_cmd_t cmd_o,
  input  nfp_pkg::dp_sts_t sts_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             converged_o,
  output logic [1:0]       root_index_o,
  output logic [7:0]       step_count_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o,
  output logic [7:0]       alpha_o
);
  import nfp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FINISH} state_e;

  state_e          state_q;
  logic [PC_W-1:0] pc_q;
  logic [7:0]      step_q;
  logic            conv_q;
  logic [1:0]      root_q;
  logic            out_valid_q, converged_q;
  logic [1:0]      root_index_q;
  logic [7:0]      step_count_q, alpha_q;
  logic [23:0]     rgb_q;
  uop_t            uop;
  logic [8:0]      step_nx;
  logic            out_load;

  assign uop        = uop_rom(pc_q);
  assign step_nx    = {1'b0, step_q} + 9'd1;
  assign in_ready_o = (state_q == S_IDLE);
  assign pix_load_o = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o.start = (state_q == S_ISSUE);
    cmd_o.uop   = uop;
    cmd_o.step  = step_q;
  end

  // State, program counter, step counter and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pc_q         <= '0;
      step_q       <= '0;
      conv_q       <= 1'b0;
      root_q       <= '0;
      out_valid_q  <= 1'b0;
      converged_q  <= 1'b0;
      root_index_q <= '0;
      step_count_q <= '0;
      rgb_q        <= '0;
      alpha_q      <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            pc_q    <= '0;
            step_q  <= '0;
            conv_q  <= 1'b0;
            root_q  <= '0;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (sts_i.done) begin
            if (sts_i.abort && (uop.op == OP_CHKOVF || uop.op == OP_CHKDD ||
                                uop.op == OP_TEST)) begin
              state_q <= S_FINISH;
            end else if (pc_q == PC_INIT_CHK) begin
              if (max_iterations_i == '0) begin
                state_q <= S_FINISH;
              end else begin
                pc_q    <= PC_LOOP;
                state_q <= S_ISSUE;
              end
            end else if (pc_q == PC_TEST) begin
              if (sts_i.hit) begin
                conv_q  <= 1'b1;
                root_q  <= sts_i.root;
                pc_q    <= PC_ALPHA;
                state_q <= S_ISSUE;
              end else if (step_nx >= {1'b0, max_iterations_i}) begin
                state_q <= S_FINISH;
              end else begin
                step_q  <= step_nx[7:0];
                pc_q    <= PC_LOOP;
                state_q <= S_ISSUE;
              end
            end else if (pc_q == PC_ALPHA) begin
              state_q <= S_FINISH;
            end else begin
              pc_q    <= pc_q + PC_W'(1);
              state_q <= S_ISSUE;
            end
          end
        end
        S_FINISH: begin
          // Wait for the output register to free up.
          if (out_load) begin
            converged_q  <= conv_q;
            root_index_q <= conv_q ? root_q : 2'd0;
            step_count_q <= conv_q ? step_q : 8'd0;
            rgb_q        <= conv_q ? palette(root_q) : 24'd0;
            alpha_q      <= conv_q ? sts_i.alpha : 8'd255;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign converged_o  = converged_q;
  assign root_index_o = root_index_q;
  assign step_count_o = step_count_q;
  assign red_o        = rgb_q[23:16];
  assign green_o      = rgb_q[15:8];
  assign blue_o       = rgb_q[7:0];
  assign alpha_o      = alpha_q;

endmodule
`default_nettype wire

FILE: design/newton_fractal_pixel_core.sv
// Newton fractal pixel core for z^3 - 1: configuration registers, controller and datapath.
//
// Usage: write offset_x, offset_y, zoom_reciprocal and max_iterations through the
// configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) while the core is idle.
// Items enter on the pixel channel (in_valid_i / in_ready_o) and leave on the
// result channel (out_valid_o / out_ready_i); one result per pixel, in order.
// One pixel is worked at a time: in_ready_o is high only when the core is idle.
// Each Newton step takes 13 products from the shared 48 x 16 multiplier,
// two quotients from the one-bit-per-cycle divider, and fourteen additions
// and checks; a hit adds the alpha division.
// The result sits in an output register; the core takes the next pixel while a
// result waits, and holds the following one at the end of its work until the
// receiver takes the earlier result.
// Reset clears the controller and loads offsets 0, zoom_reciprocal 83886 and
// max_iterations 50; no result is pending after reset.
`default_nettype none
module newton_fractal_pixel_core #(
  parameter int unsigned IMAGE_WIDTH  = nfp_pkg::IMAGE_WIDTH_DEF,
  parameter int unsigned IMAGE_HEIGHT = nfp_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nfp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [9:0]                     pixel_x_i,
  input  logic [9:0]                     pixel_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           converged_o,
  output logic [1:0]                     root_index_o,
  output logic [7:0]                     step_count_o,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o,
  output logic [7:0]                     alpha_o
);
  import nfp_pkg::*;

  logic [15:0] offset_x_q, offset_y_q;
  logic [31:0] zoom_rec_q;
  logic [7:0]  max_iter_q;
  logic        pix_load;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
      zoom_rec_q <= ZOOM_RESET;
      max_iter_q <= MAX_ITER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OFFSET_X: offset_x_q <= cfg_data_i[15:0];
        CFG_OFFSET_Y: offset_y_q <= cfg_data_i[15:0];
        CFG_ZOOM_REC: zoom_rec_q <= cfg_data_i;
        CFG_MAX_ITER: max_iter_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  nfp_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pix_load_o       (pix_load),
    .max_iterations_i (max_iter_q),
    .cmd_o            (cmd),
    .sts_i            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .converged_o      (converged_o),
    .root_index_o     (root_index_o),
    .step_count_o     (step_count_o),
    .red_o            (red_o),
    .green_o          (green_o),
    .blue_o           (blue_o),
    .alpha_o          (alpha_o)
  );

  nfp_datapath #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .pix_load_i        (pix_load),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .offset_x_i        (offset_x_q),
    .offset_y_i        (offset_y_q),
    .zoom_reciprocal_i (zoom_rec_q),
    .max_iterations_i  (max_iter_q),
    .sts_o             (sts)
  );

  // An accepted pixel starts the first operation in the next cycle.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> cmd.start)
    else $error("accepted item did not start the datapath");

  // The datapath is never started while it still finishes an operation.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> !sts.done)
    else $error("datapath started while busy");

  // A black result is opaque, with zero red, root index and step count.
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !converged_o |-> alpha_o == 8'd255 && red_o == 8'd0 &&
      root_index_o == 2'd0 && step_count_o == 8'd0)
    else $error("unconverged result not black");

  // A converged result names one of the three roots.
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && converged_o |-> root_index_o != 2'd3)
    else $error("invalid root index");

endmodule
`default_nettype wire

FILE: tb/tb_newton_fractal_pixel_core.sv
// Testbench for the Newton fractal pixel core: bit-exact pixel predictor with randomized flow.
`timescale 1ns / 1ps
module tb_newton_fractal_pixel_core;
  import nfp_pkg::*;

  localparam longint FXL_MAX = 64'sd140737488355327;
  localparam longint FXL_MIN = -64'sd140737488355328;
  localparam longint FXL_ONE = 64'sd4294967296;
  localparam longint FXL_HALF = 64'sd2147483648;
  localparam longint FXL_S3H = 64'sd3719550787;
  localparam longint FXL_TOL = 64'sd429;
  localparam longint CYCLE_LIMIT = 150000000;

  typedef struct packed {
    logic       converged;
    logic [1:0] root_index;
    logic [7:0] step_count;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_color_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [9:0]            pixel_x_i;
  logic [9:0]            pixel_y_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  converged_o;
  logic [1:0]            root_index_o;
  logic [7:0]            step_count_o;
  logic [7:0]            red_o;
  logic [7:0]            green_o;
  logic [7:0]            blue_o;
  logic [7:0]            alpha_o;

  newton_fractal_pixel_core DUT (.*);

  // Shadow copy of the view registers.
  logic signed [15:0] view_off_x;
  logic signed [15:0] view_off_y;
  logic [31:0]        view_zoom_rec;
  logic [7:0]         view_max_iter;

  pixel_color_t expected_colors[$];
  bit           overflowed;
  bit           failed;
  bit           quiet;
  longint       cycles;
  int           stall_left;

  // Clock and cycle limit.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Fixed-point helpers in Q15.32.
  function automatic longint fx_clip(input longint v);
    if (v > FXL_MAX) begin
      overflowed = 1'b1;
      return FXL_MAX;
    end
    if (v < FXL_MIN) begin
      overflowed = 1'b1;
      return FXL_MIN;
    end
    return v;
  endfunction

  function automatic bit [63:0] fx_abs(input longint a);
    return a < 0 ? 64'd0 - 64'(a) : 64'(a);
  endfunction

  function automatic longint fx_signed(input bit [63:0] r, input bit neg);
    bit [63:0] lim;
    lim = 64'd1 << 47;
    if (r > lim || (r == lim && !neg)) begin
      overflowed = 1'b1;
      return neg ? FXL_MIN : FXL_MAX;
    end
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    bit [63:0] ua, ub, ah, al, bh, bl, r;
    ua = fx_abs(a);
    ub = fx_abs(b);
    ah = ua >> 32;
    al = ua & 64'hFFFF_FFFF;
    bh = ub >> 32;
    bl = ub & 64'hFFFF_FFFF;
    r = ((ah * bh) << 32) + (ah * bl + al * bh) + ((al * bl + (64'd1 << 31)) >> 32);
    return fx_signed(r, (a < 0) != (b < 0));
  endfunction

  // Quotient magnitude truncated toward zero; the divisor is positive.
  function automatic longint fx_div(input longint n, input longint d);
    bit [63:0] un, ud, whole, rem, frac;
    un = fx_abs(n);
    ud = 64'(d);
    whole = un / ud;
    rem = un % ud;
    frac = 0;
    if (whole > 64'd32768) begin
      overflowed = 1'b1;
      return n < 0 ? FXL_MIN : FXL_MAX;
    end
    for (int i = 0; i < 32; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= ud) begin
        rem = rem - ud;
        frac[0] = 1'b1;
      end
    end
    return fx_signed((whole << 32) | frac, n < 0);
  endfunction

  // Color of one pixel under the current view registers.
  function automatic pixel_color_t newton_color(input logic [9:0] px, input logic [9:0] py);
    pixel_color_t c;
    longint zr, zi, z2r, z2i, z3r, z3i, nr, ni, dr, di, dd, qr, qi, t, er, ei;
    longint rre[3];
    longint rim[3];
    logic [23:0] pal[3];
    rre = '{FXL_ONE, -FXL_HALF, -FXL_HALF};
    rim = '{64'sd0, FXL_S3H, -FXL_S3H};
    pal = '{{8'd154, 8'd93, 8'd93}, {8'd109, 8'd167, 8'd109}, {8'd99, 8'd129, 8'd159}};
    c = '0;
    c.alpha = 8'd255;
    overflowed = 1'b0;
    zr = fx_clip((2 * longint'(px) - 800 + 2 * longint'(view_off_x))
                 * longint'(view_zoom_rec) * 128);
    zi = fx_clip((600 + 2 * longint'(view_off_y) - 2 * longint'(py))
                 * longint'(view_zoom_rec) * 128);
    if (overflowed) return c;
    for (int s = 0; s < int'(view_max_iter); s++) begin
      z2r = fx_clip(fx_mul(zr, zr) - fx_mul(zi, zi));
      t = fx_mul(zr, zi);
      z2i = fx_clip(t + t);
      z3r = fx_clip(fx_mul(z2r, zr) - fx_mul(z2i, zi));
      z3i = fx_clip(fx_mul(z2r, zi) + fx_mul(z2i, zr));
      nr = fx_clip(z3r - FXL_ONE);
      ni = z3i;
      dr = fx_clip(3 * z2r);
      di = fx_clip(3 * z2i);
      dd = fx_clip(fx_mul(dr, dr) + fx_mul(di, di));
      if (overflowed || dd <= 0) return c;
      qr = fx_div(fx_clip(fx_mul(nr, dr) + fx_mul(ni, di)), dd);
      qi = fx_div(fx_clip(fx_mul(ni, dr) - fx_mul(nr, di)), dd);
      zr = fx_clip(zr - qr);
      zi = fx_clip(zi - qi);
      if (overflowed) return c;
      for (int k = 0; k < 3; k++) begin
        er = zr - rre[k];
        ei = zi - rim[k];
        if (er < FXL_TOL && er > -FXL_TOL && ei < FXL_TOL && ei > -FXL_TOL) begin
          c.converged = 1'b1;
          c.root_index = 2'(k);
          c.step_count = 8'(s);
          {c.red, c.green, c.blue} = pal[k];
          c.alpha = 8'((s * 255) / int'(view_max_iter));
          return c;
        end
      end
    end
    return c;
  endfunction

  // Result receiver stalls in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left <= 0;
    end else if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Each result is taken at the next rising edge; compare it with the oldest expectation.
  always @(negedge clk_i) begin
    pixel_color_t want;
    pixel_color_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {converged_o, root_index_o, step_count_o, red_o, green_o, blue_o, alpha_o};
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        failed = 1'b1;
      end else begin
        want = expected_colors.pop_front();
        if (want.converged !== got.converged) begin
          $display("%0t: converged expected %0d actual %0d", $realtime, want.converged,
                   got.converged);
          failed = 1'b1;
        end
        if (want.root_index !== got.root_index) begin
          $display("%0t: root_index expected %0d actual %0d", $realtime, want.root_index,
                   got.root_index);
          failed = 1'b1;
        end
        if (want.step_count !== got.step_count) begin
          $display("%0t: step_count expected %0d actual %0d", $realtime, want.step_count,
                   got.step_count);
          failed = 1'b1;
        end
        if (want.red !== got.red) begin
          $display("%0t: red expected %0d actual %0d", $realtime, want.red, got.red);
          failed = 1'b1;
        end
        if (want.green !== got.green) begin
          $display("%0t: green expected %0d actual %0d", $realtime, want.green, got.green);
          failed = 1'b1;
        end
        if (want.blue !== got.blue) begin
          $display("%0t: blue expected %0d actual %0d", $realtime, want.blue, got.blue);
          failed = 1'b1;
        end
        if (want.alpha !== got.alpha) begin
          $display("%0t: alpha expected %0d actual %0d", $realtime, want.alpha, got.alpha);
          failed = 1'b1;
        end
      end
    end
  end

  // Sends one pixel; returns just after the edge that accepted it.
  task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
    bit took;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    pixel_x_i <= px;
    pixel_y_i <= py;
    in_valid_i <= 1'b1;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    expected_colors.push_back(newton_color(px, py));
  endtask

  // Waits until every expected result is back and the core has settled.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Writes all four view registers while the core is idle.
  task automatic set_view(input logic signed [15:0] ox, input logic signed [15:0] oy,
                          input logic [31:0] zr, input logic [7:0] iters);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_OFFSET_X;
    cfg_data_i <= 32'(ox);
    @(posedge clk_i);
    cfg_idx_i <= CFG_OFFSET_Y;
    cfg_data_i <= 32'(oy);
    @(posedge clk_i);
    cfg_idx_i <= CFG_ZOOM_REC;
    cfg_data_i <= zr;
    @(posedge clk_i);
    cfg_idx_i <= CFG_MAX_ITER;
    cfg_data_i <= 32'(iters);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    view_off_x = ox;
    view_off_y = oy;
    view_zoom_rec = zr;
    view_max_iter = iters;
    @(posedge clk_i);
  endtask

  // Reset view: zero divisor at the center, a root at the first step, corners, edge, outside.
  task automatic test_reset_view;
    send_pixel(10'd400, 10'd300);
    send_pixel(10'd600, 10'd300);
    send_pixel(10'd300, 10'd127);
    send_pixel(10'd300, 10'd473);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd799, 10'd599);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd0);
  endtask

  // Register extremes: no steps, one step, overflow at start, tiny zoom, longest limit.
  task automatic test_register_extremes;
    set_view(16'sd0, 16'sd0, 32'd83886, 8'd0);
    send_pixel(10'd600, 10'd300);
    set_view(16'sd0, 16'sd0, 32'd83886, 8'd1);
    send_pixel(10'd600, 10'd300);
    send_pixel(10'd620, 10'd310);
    set_view(16'sh7FFF, -16'sh8000, 32'hFFFF_FFFF, 8'd255);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    set_view(-16'sh8000, 16'sh7FFF, 32'd1, 8'd255);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    set_view(16'sd0, 16'sd0, 32'd83886, 8'd255);
    send_pixel(10'd605, 10'd302);
    send_pixel(10'd300, 10'd470);
    send_pixel(10'd400, 10'd300);
  endtask

  // Random views and pixels, mostly with short step limits.
  task automatic test_random_views(input int phases, input int per_phase);
    logic [31:0] zr;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 9))
        0:       zr = $urandom_range(1, 1000);
        1:       zr = $urandom();
        default: zr = $urandom_range(20000, 400000);
      endcase
      set_view(16'($urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 400) - 200),
               16'($urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 400) - 200),
               zr, 8'($urandom_range(0, 19) == 0 ? $urandom() : $urandom_range(1, 24)));
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 9) == 0) send_pixel(10'($urandom()), 10'($urandom()));
        else send_pixel(10'($urandom_range(0, 799)), 10'($urandom_range(0, 599)));
        if (i == per_phase / 2 && $urandom_range(0, 1) == 0) drain();
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    pixel_x_i = '0;
    pixel_y_i = '0;
    failed = 1'b0;
    quiet = 1'b0;
    cycles = 0;
    view_off_x = 16'sd0;
    view_off_y = 16'sd0;
    view_zoom_rec = 32'd83886;
    view_max_iter = 8'd50;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_view();
    test_register_extremes();
    test_random_views(7, 50);
    quiet = 1'b1;
    test_random_views(1, 40);

    drain();
    repeat (100) @(posedge clk_i);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
